// ===== rtl/core/spq_pkg.sv =====
// Shared types, codes and arithmetic helpers for the sorted priority queue.
package spq_pkg;

  localparam int unsigned ID_W      = 16;
  localparam int unsigned PRIO_W    = 7;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned SERVICE_W = 17;

  localparam logic [PRIO_W-1:0]    PRIO_MIN     = 7'd1;
  localparam logic [PRIO_W-1:0]    PRIO_MAX     = 7'd100;
  localparam logic [SERVICE_W-1:0] SERVICE_BASE = 17'd100;
  localparam logic [SERVICE_W-1:0] SERVICE_MULT = 17'd10;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_REMOVED   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  // One held entry
  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [PRIO_W-1:0]    prio;
    logic [TIME_W-1:0]    arrival;
    logic [SERVICE_W-1:0] service;
  } entry_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [PRIO_W-1:0] prio;
  } ctrl_t;

  // Clamp a priority into the legal range
  function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
    logic [PRIO_W-1:0] r;
    r = p;
    if (p < PRIO_MIN) r = PRIO_MIN;
    if (p > PRIO_MAX) r = PRIO_MAX;
    return r;
  endfunction

  // Service time: base plus fixed surcharge plus ten times priority
  function automatic logic [SERVICE_W-1:0] calc_service(input logic [TIME_W-1:0] base,
                                                        input logic [PRIO_W-1:0] p);
    logic [SERVICE_W-1:0] m;
    m = SERVICE_MULT * {{(SERVICE_W-PRIO_W){1'b0}}, p};
    return {1'b0, base} + SERVICE_BASE + m;
  endfunction

endpackage

// ===== rtl/core/spq_cell.sv =====
// One slot of the shift-register queue: hold, take the new entry, or shift.
module spq_cell (
  input  logic           clk,
  input  spq_pkg::ctrl_t  ctrl,
  input  spq_pkg::entry_t new_entry,
  input  spq_pkg::entry_t left_entry,
  input  spq_pkg::entry_t right_entry,
  input  logic           left_keep,
  input  logic           occupied,
  output spq_pkg::entry_t entry,
  output logic           keep
);

  // Stay put on insert when held entry ranks equal or higher
  assign keep = occupied && (entry.prio >= ctrl.prio);

  // Insert: hold, take new at the boundary, else shift toward the tail.
  // Remove: shift toward the head. Idle: hold.
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!keep) begin
        entry <= left_keep ? new_entry : left_entry;
      end
    end else if (ctrl.rem) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: controller, counters and row of cells.
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------------
//   command  | start, busy          | op, prio_in, arrival_in, base_service_in
//   result   | done (one-cycle)     | status, entry_id, entry_prio, entry_arrival,
//            |                      | entry_service, occupancy
//
// A command beat is taken at every edge with start high; busy stays low.
// Its result beat is registered and shows on done in the next cycle, for one cycle only.
// All cells compare against the new priority and shift in that same cycle.
// Reset clears the fill count, the id counter and done; cell contents stay as is.
// The receiver cannot stall, so back-to-back commands give back-to-back results.
module sorted_priority_queue #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [6:0]  prio_in,
  input  logic [15:0] arrival_in,
  input  logic [15:0] base_service_in,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] entry_id,
  output logic [6:0]  entry_prio,
  output logic [15:0] entry_arrival,
  output logic [16:0] entry_service,
  output logic [6:0]  occupancy
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [15:0]     next_id;
  logic [15:0]     next_id_next;
  logic            accept;
  logic            is_full;
  logic            is_empty;
  spq_pkg::ctrl_t  ctrl;
  spq_pkg::entry_t new_entry;
  spq_pkg::entry_t cell_entry [CAPACITY];
  logic            cell_keep  [CAPACITY];
  spq_pkg::entry_t res_entry;
  spq_pkg::status_t res_status;
  logic [CW+6:0]   occ_wide;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_full  = (count == CW'(CAPACITY));
  assign is_empty = (count == '0);

  // Build the entry an insert would store
  always_comb begin
    new_entry.prio    = spq_pkg::clamp_prio(prio_in);
    new_entry.id      = next_id + 16'd1;
    new_entry.arrival = arrival_in;
    new_entry.service = spq_pkg::calc_service(base_service_in, new_entry.prio);
  end

  // Decode the command beat into cell control, counters and result
  always_comb begin
    ctrl.ins     = 1'b0;
    ctrl.rem     = 1'b0;
    ctrl.prio    = new_entry.prio;
    count_next   = count;
    next_id_next = next_id;
    res_entry    = '0;
    res_status   = spq_pkg::ST_INSERTED;
    unique case (spq_pkg::op_t'(op))
      spq_pkg::OP_INSERT: begin
        if (is_full) begin
          res_status = spq_pkg::ST_OVERFLOW;
        end else begin
          ctrl.ins     = accept;
          count_next   = count + CW'(1);
          next_id_next = new_entry.id;
          res_entry    = new_entry;
          res_status   = spq_pkg::ST_INSERTED;
        end
      end
      spq_pkg::OP_REMOVE: begin
        if (is_empty) begin
          res_status = spq_pkg::ST_UNDERFLOW;
        end else begin
          ctrl.rem   = accept;
          count_next = count - CW'(1);
          res_entry  = cell_entry[0];
          res_status = spq_pkg::ST_REMOVED;
        end
      end
      default: begin
        res_status = spq_pkg::ST_INSERTED;
      end
    endcase
  end

  // Row of cells; cell 0 is the head
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t left_e;
    spq_pkg::entry_t right_e;
    logic            left_k;
    if (i == 0) begin : g_head
      assign left_e = new_entry;
      assign left_k = 1'b1;
    end else begin : g_mid
      assign left_e = cell_entry[i-1];
      assign left_k = cell_keep[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_body
      assign right_e = cell_entry[i+1];
    end
    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .right_entry (right_e),
      .left_keep   (left_k),
      .occupied    (count > CW'(i)),
      .entry       (cell_entry[i]),
      .keep        (cell_keep[i])
    );
  end

  // Advance fill count and id counter on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      next_id <= '0;
      done    <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count   <= count_next;
        next_id <= next_id_next;
      end
    end
  end

  assign occ_wide = {7'd0, count_next};

  // Register the result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= res_status;
      entry_id      <= res_entry.id;
      entry_prio    <= res_entry.prio;
      entry_arrival <= res_entry.arrival;
      entry_service <= res_entry.service;
      occupancy     <= occ_wide[6:0];
    end
  end

endmodule
